FILE: rtl/mmh3_pkg.sv
// Package for the MurmurHash3 x86_32 hasher: mixing constants, queue entry
// type and sizes shared by the front, queue and back modules.
// Depends on nothing.
`default_nettype none

package mmh3_pkg;

    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;
    localparam logic [31:0] SEED     = 32'h00000000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int TAIL_CNT_W = 2;

    typedef enum logic [1:0] {
        KIND_FULL,
        KIND_FULL_LAST,
        KIND_TAIL,
        KIND_EMPTY
    } t_kind;

    typedef struct packed {
        logic [31:0]           k;
        t_kind                 kind;
        logic [TAIL_CNT_W-1:0] cnt;
    } t_blend;

    function automatic logic [31:0] tail_mask(input logic [TAIL_CNT_W-1:0] cnt);
        logic [31:0] m;
        begin
            unique case (cnt)
                2'd1:    m = 32'h000000ff;
                2'd2:    m = 32'h0000ffff;
                2'd3:    m = 32'h00ffffff;
                default: m = 32'hffffffff;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mmh3_front.sv
// Front end of the hasher: accepts words, classifies them and runs the
// two-multiply blend in two registered stages. Depends on mmh3_pkg.
`default_nettype none

module mmh3_front import mmh3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    input  wire logic        i_full,
    output logic             o_push,
    output t_blend           o_push_data
);

    logic   r_s1_v;
    t_blend r_s1;
    logic   r_s2_v;
    t_blend r_s2;

    logic   s1_adv;
    logic   s2_adv;
    t_blend n_s1;
    t_blend n_s2;
    logic [31:0] masked;
    logic [31:0] rot15;

    assign s2_adv  = !r_s2_v || !i_full;
    assign s1_adv  = !r_s1_v || s2_adv;
    assign o_stall = !s1_adv;

    always_comb begin
        n_s1.cnt = i_byte_count[TAIL_CNT_W-1:0];
        priority if (!i_last) begin
            n_s1.kind = KIND_FULL;
        end else if (i_byte_count[2]) begin
            n_s1.kind = KIND_FULL_LAST;
        end else if (i_byte_count == 3'd0) begin
            n_s1.kind = KIND_EMPTY;
        end else begin
            n_s1.kind = KIND_TAIL;
        end
        masked = i_data_word;
        if (n_s1.kind == KIND_TAIL) begin
            masked = i_data_word & tail_mask(n_s1.cnt);
        end
        n_s1.k = masked * MIX_C1;
    end

    always_comb begin
        rot15  = {r_s1.k[16:0], r_s1.k[31:17]};
        n_s2   = r_s1;
        n_s2.k = rot15 * MIX_C2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= i_valid;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (s2_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_push      = r_s2_v && !i_full;
    assign o_push_data = r_s2;

endmodule

`default_nettype wire

FILE: rtl/mmh3_fifo.sv
// Short queue of blended words between the front and back ends.
// Depends on mmh3_pkg for the entry type and depth.
`default_nettype none

module mmh3_fifo import mmh3_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_blend i_push_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_avail,
    output t_blend      o_pop_data
);

    t_blend                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        begin
            if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
                return '0;
            end
            return p + FIFO_PTR_W'(1);
        end
    endfunction

    assign o_full     = r_count == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_avail    = r_count != '0;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mmh3_back.sv
// Back end of the hasher: folds blended words into the running hash, counts
// bytes, and runs the finalizer into the output register. Depends on mmh3_pkg.
`default_nettype none

module mmh3_back import mmh3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_avail,
    input  wire t_blend      i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_hash_value
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } t_state;

    t_state      r_state;
    logic [31:0] r_hash;
    logic [31:0] r_total;
    logic [31:0] r_f;
    logic        r_out_v;
    logic [31:0] r_out;

    logic [31:0] n_fold;
    logic [31:0] n_total4;
    logic [31:0] n_total_tail;
    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] f1x;
    logic [31:0] f2x;
    logic        out_free;

    always_comb begin
        hx           = r_hash ^ i_entry.k;
        hr           = {hx[18:0], hx[31:19]};
        n_fold       = hr + {hr[29:0], 2'b00} + FOLD_ADD;
        n_total4     = r_total + 32'd4;
        n_total_tail = r_total + {{(32 - TAIL_CNT_W){1'b0}}, i_entry.cnt};
        f1x          = r_f ^ {16'd0, r_f[31:16]};
        f2x          = r_f ^ {13'd0, r_f[31:13]};
    end

    assign o_pop    = (r_state == ST_RUN) && i_avail;
    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_hash  <= SEED;
            r_total <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_state == ST_FIN3 && out_free) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (i_avail) begin
                        unique case (i_entry.kind)
                            KIND_FULL: begin
                                r_hash  <= n_fold;
                                r_total <= n_total4;
                            end
                            KIND_FULL_LAST: begin
                                r_f     <= n_fold ^ n_total4;
                                r_hash  <= SEED;
                                r_total <= '0;
                                r_state <= ST_FIN1;
                            end
                            KIND_TAIL: begin
                                r_f     <= hx ^ n_total_tail;
                                r_hash  <= SEED;
                                r_total <= '0;
                                r_state <= ST_FIN1;
                            end
                            default: begin
                                r_f     <= r_hash ^ r_total;
                                r_hash  <= SEED;
                                r_total <= '0;
                                r_state <= ST_FIN1;
                            end
                        endcase
                    end
                end
                ST_FIN1: begin
                    r_f     <= f1x * FIN_M1;
                    r_state <= ST_FIN2;
                end
                ST_FIN2: begin
                    r_f     <= f2x * FIN_M2;
                    r_state <= ST_FIN3;
                end
                default: begin
                    if (out_free) begin
                        r_out   <= f1x;
                        r_state <= ST_RUN;
                    end
                end
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_hash_value = r_out;

    a_no_pop_while_finishing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_pop)
        else $error("queue popped while the finalizer is busy");

    a_end_enters_finalizer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.kind != KIND_FULL) |=> (r_state == ST_FIN1))
        else $error("message end did not start the finalizer");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.kind != KIND_FULL) |=> (r_hash == SEED && r_total == '0))
        else $error("running hash or length not cleared after a message");

    a_result_only_from_fin3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> ($past(r_state) == ST_FIN3 && r_state == ST_RUN))
        else $error("result appeared outside the final finalizer step");

endmodule

`default_nettype wire

FILE: rtl/murmur3_32_hash.sv
// Throughput: one word per cycle inside a message while the queue is not full,
// set by the blend pipeline and the fold; each message end keeps the back end
// from popping while the finalizer runs through ST_FIN1, ST_FIN2 and ST_FIN3,
// longer if the output is stalled.
// Reset is synchronous and active low; it empties the pipeline and queue and
// clears the running hash and length. Depends on mmh3_pkg, front, fifo, back.
`default_nettype none

module murmur3_32_hash import mmh3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_hash_value
);

    logic   push;
    t_blend push_data;
    logic   full;
    logic   pop;
    logic   avail;
    t_blend pop_data;

    mmh3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_full       (full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    mmh3_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_avail     (avail),
        .o_pop_data  (pop_data)
    );

    mmh3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (avail),
        .i_entry      (pop_data),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire

FILE: tb/tb_murmur3_32_hash.sv
// Self-checking testbench for murmur3_32_hash: a directed table and random messages are
// hashed by an in-bench predictor and compared with every returned hash, under random idling.
// Depends on mmh3_pkg and murmur3_32_hash.
`default_nettype none

module tb_murmur3_32_hash;
    import mmh3_pkg::*;

    localparam int ITEMS     = 950;
    localparam int QUIET_AT  = ITEMS - 100;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 64;
    localparam int DRAIN     = 40;
    localparam int MAX_SHOWN = 10;
    localparam int DIR_N     = 23;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
        logic        known;
        logic [31:0] hash;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_last;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_hash_value;

    logic [31:0] msg_hash;
    logic [31:0] msg_len;
    logic [31:0] hash_q[$];

    int n_words   = 0;
    int n_msgs    = 0;
    int n_checked = 0;
    int n_fail    = 0;
    int tx_idle_pct = 20;
    bit quiet     = 1'b0;
    bit hold_done = 1'b0;
    int stall_left = 0;
    int calm_left  = 0;

    t_row stim_rows [DIR_N] = '{
        '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
        '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
        '{32'h000000ff, 3'd1, 1'b1, 1'b0, 32'h0},
        '{32'hdeadbeef, 3'd2, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
        '{32'h00000000, 3'd7, 1'b1, 1'b0, 32'h0},
        '{32'h80000000, 3'd5, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd6, 1'b1, 1'b0, 32'h0},
        '{32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},
        '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
        '{32'h00000000, 3'd6, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0},
        '{32'ha5a5a5a5, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'h01020304, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hfedcba98, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h00000001, 3'd4, 1'b1, 1'b0, 32'h0},
        '{32'h5a5a5a5a, 3'd2, 1'b0, 1'b0, 32'h0},
        '{32'h3c3c3c3c, 3'd5, 1'b0, 1'b0, 32'h0},
        '{32'hffffff00, 3'd2, 1'b1, 1'b0, 32'h0},
        '{32'h7fffffff, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd0, 1'b1, 1'b0, 32'h0}
    };

    murmur3_32_hash u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rotl32(t, 15);
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        return t ^ (t >> 16);
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 32'hffffffff;
        end else if (pick == 1) begin
            return 32'h00000000;
        end
        return $urandom;
    endfunction

    task automatic absorb_word(input logic [31:0] w, input logic [2:0] c, input logic l,
                               output bit done, output logic [31:0] digest);
        logic [31:0] h;
        logic [31:0] mask;
        done = 1'b0;
        digest = 32'h0;
        if (!l || c >= 3'd4) begin
            h = msg_hash ^ blend(w);
            msg_hash = rotl32(h, 13) * 32'd5 + FOLD_ADD;
            msg_len = msg_len + 32'd4;
        end
        if (l) begin
            h = msg_hash;
            if (c != 3'd0 && c < 3'd4) begin
                mask = (32'h1 << (8 * c)) - 32'h1;
                h = h ^ blend(w & mask);
                msg_len = msg_len + 32'(c);
            end
            digest = avalanche(h ^ msg_len);
            done = 1'b1;
            msg_hash = SEED;
            msg_len = 32'h0;
        end
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic l,
                             input logic known, input logic [31:0] fixed);
        bit done;
        logic [31:0] digest;
        i_valid <= 1'b1;
        i_data_word <= w;
        i_byte_count <= c;
        i_last <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_word(w, c, l, done, digest);
        n_words++;
        if (done) begin
            hash_q.push_back(known ? fixed : digest);
            n_msgs++;
        end
        if (n_words >= QUIET_AT) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            i_data_word <= $urandom;
            i_byte_count <= 3'($urandom);
            i_last <= 1'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_message();
        int len;
        bit noisy;
        noisy = ($urandom_range(0, 9) == 0);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            send_word(rand_word(), noisy ? 3'($urandom) : 3'd4, 1'b0, 1'b0, 32'h0);
        end
        send_word(rand_word(), noisy ? 3'($urandom) : 3'($urandom_range(0, 4)), 1'b1,
                  1'b0, 32'h0);
    endtask

    // Output side: random stall bursts, one long hold to back up the pipeline,
    // and the in-order check of every hash transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hash_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN)
                        $display("unexpected hash transaction: got %08h", o_hash_value);
                end else begin
                    n_checked++;
                    if (o_hash_value !== hash_q[0]) begin
                        n_fail++;
                        if (n_fail <= MAX_SHOWN)
                            $display("hash mismatch #%0d: expected %08h, got %08h",
                                     n_checked, hash_q[0], o_hash_value);
                    end
                    void'(hash_q.pop_front());
                end
            end

            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else if (!hold_done && n_words >= HOLD_AT) begin
                i_stall <= 1'b1;
                stall_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (i_stall) begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0) calm_left <= $urandom_range(20, 60);
            end else if (calm_left > 0) begin
                calm_left <= calm_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_word = 32'h0;
        i_byte_count = 3'd0;
        i_last = 1'b0;
        msg_hash = SEED;
        msg_len = 32'h0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_word(stim_rows[r].word, stim_rows[r].cnt, stim_rows[r].last,
                      stim_rows[r].known, stim_rows[r].hash);
        end

        while (n_words < ITEMS) begin
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 20;
                default: tx_idle_pct = 45;
            endcase
            send_message();
        end
        i_valid <= 1'b0;

        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Hashed %0d words in %0d messages, %0d hashes checked, %0d failures.",
                 n_words, n_msgs, n_checked, n_fail);
        $display("Covered empty, tail and full endings, odd byte counts, idle bursts "
                 , "and a long output hold.");
        if (n_fail == 0) begin
            $display("[murmur3_32_hash] OK");
        end else begin
            $display("[murmur3_32_hash] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d hashes outstanding.", hash_q.size());
        $display("[murmur3_32_hash] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
